FILE: rtl/core/gravity_particle_step_defines.svh
// assertion macros for the gravity particle step core
`ifndef GRAVITY_PARTICLE_STEP_DEFINES_SVH
`define GRAVITY_PARTICLE_STEP_DEFINES_SVH

// same-cycle implication
`define GPS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/gps_pkg.sv
// package with the pipeline payload type and per-stage arithmetic
`default_nettype none
package gps_pkg;

	typedef enum logic [0:0] {
		RegGravityX = 1'b0,
		RegGravityY = 1'b1
	} reg_index_t;

	localparam logic signed [21:0] GravScale = 22'sd1288490;
	localparam logic signed [41:0] Max42 = 42'sd549755813887;
	localparam logic signed [41:0] Min42 = -42'sd549755813888;

	localparam int unsigned KAbs    = 0;
	localparam int unsigned KMsb    = 1;
	localparam int unsigned KShift  = 2;
	localparam int unsigned KSq     = 3;
	localparam int unsigned KSum    = 4;
	localparam int unsigned KRoot0  = 5;
	localparam int unsigned RootN   = 32;
	localparam int unsigned KDivSet = KRoot0 + RootN;
	localparam int unsigned KDiv0   = KDivSet + 1;
	localparam int unsigned DivN    = 24;
	localparam int unsigned KSign   = KDiv0 + DivN;
	localparam int unsigned KPart   = KSign + 1;
	localparam int unsigned KProd   = KSign + 2;
	localparam int unsigned KRound  = KSign + 3;
	localparam int unsigned KRad    = KSign + 4;
	localparam int unsigned KTan    = KSign + 5;
	localparam int unsigned KVel    = KSign + 6;
	localparam int unsigned KPos    = KSign + 7;
	localparam int unsigned NStages = KPos + 1;

	typedef struct packed {
		logic signed [39:0] px;
		logic signed [39:0] py;
		logic signed [39:0] vx;
		logic signed [39:0] vy;
		logic signed [39:0] ar;
		logic signed [39:0] at;
		logic signed [39:0] ax;
		logic signed [39:0] ay;
		logic               alive;
		logic               zero;
		logic signed [40:0] rx;
		logic signed [40:0] ry;
		logic [40:0]        mx;
		logic [40:0]        my;
		logic [40:0]        big;
		logic [5:0]         lead;
		logic [61:0]        sqx;
		logic [61:0]        sqy;
		logic [63:0]        rem;
		logic [63:0]        root;
		logic [31:0]        len;
		logic [54:0]        dnx;
		logic [54:0]        dny;
		logic [32:0]        rqx;
		logic [32:0]        rqy;
		logic [23:0]        qx;
		logic [23:0]        qy;
		logic signed [24:0] nx;
		logic signed [24:0] ny;
		logic signed [44:0] ph0;
		logic signed [44:0] ph1;
		logic signed [44:0] ph2;
		logic signed [44:0] ph3;
		logic signed [45:0] pl0;
		logic signed [45:0] pl1;
		logic signed [45:0] pl2;
		logic signed [45:0] pl3;
		logic signed [64:0] pr0;
		logic signed [64:0] pr1;
		logic signed [64:0] pr2;
		logic signed [64:0] pr3;
		logic signed [40:0] tr0;
		logic signed [40:0] tr1;
		logic signed [40:0] tr2;
		logic signed [40:0] tr3;
	} pipe_t;

	function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
		logic signed [39:0] r;
		if (v > Max42) begin
			r = Max42[39:0];
		end else if (v < Min42) begin
			r = Min42[39:0];
		end else begin
			r = v[39:0];
		end
		return r;
	endfunction

	function automatic pipe_t stage_op(input int unsigned k, input pipe_t p,
			input logic signed [39:0] gax, input logic signed [39:0] gay);
		pipe_t r;
		logic [63:0] bitv;
		logic [63:0] t64;
		logic [32:0] tx;
		logic [32:0] ty;
		int unsigned i;
		r = p;
		case (k)
			KAbs: begin
				r.mx = p.rx[40] ? 41'(-p.rx) : 41'(p.rx);
				r.my = p.ry[40] ? 41'(-p.ry) : 41'(p.ry);
				r.big = (r.mx > r.my) ? r.mx : r.my;
				r.zero = (r.big == 41'd0);
			end
			KMsb: begin
				r.lead = 6'd0;
				for (int b = 0; b < 41; b++) begin
					if (p.big[b]) r.lead = 6'(b);
				end
			end
			KShift: begin
				if (p.lead > 6'd30) begin
					r.mx = p.mx >> (p.lead - 6'd30);
					r.my = p.my >> (p.lead - 6'd30);
				end else begin
					r.mx = p.mx << (6'd30 - p.lead);
					r.my = p.my << (6'd30 - p.lead);
				end
			end
			KSq: begin
				r.sqx = p.mx[30:0] * p.mx[30:0];
				r.sqy = p.my[30:0] * p.my[30:0];
			end
			KSum: begin
				r.rem = 64'(p.sqx) + 64'(p.sqy);
				r.root = 64'd0;
			end
			KDivSet: begin
				r.len = p.root[31:0];
				r.dnx = {p.mx[30:0], 23'd0} + 55'(p.root[31:1]);
				r.dny = {p.my[30:0], 23'd0} + 55'(p.root[31:1]);
				r.rqx = {2'b00, r.dnx[54:24]};
				r.rqy = {2'b00, r.dny[54:24]};
				r.qx = 24'd0;
				r.qy = 24'd0;
			end
			KSign: begin
				if (p.zero) begin
					r.nx = 25'sd0;
					r.ny = 25'sd0;
				end else begin
					r.nx = p.rx[40] ? -$signed({1'b0, p.qx}) : $signed({1'b0, p.qx});
					r.ny = p.ry[40] ? -$signed({1'b0, p.qy}) : $signed({1'b0, p.qy});
				end
			end
			KPart: begin
				r.ph0 = p.nx * $signed(p.ar[39:20]);
				r.pl0 = p.nx * $signed({1'b0, p.ar[19:0]});
				r.ph1 = p.ny * $signed(p.ar[39:20]);
				r.pl1 = p.ny * $signed({1'b0, p.ar[19:0]});
				r.ph2 = p.ny * $signed(p.at[39:20]);
				r.pl2 = p.ny * $signed({1'b0, p.at[19:0]});
				r.ph3 = p.nx * $signed(p.at[39:20]);
				r.pl3 = p.nx * $signed({1'b0, p.at[19:0]});
			end
			KProd: begin
				r.pr0 = (65'(p.ph0) <<< 20) + 65'(p.pl0);
				r.pr1 = (65'(p.ph1) <<< 20) + 65'(p.pl1);
				r.pr2 = (65'(p.ph2) <<< 20) + 65'(p.pl2);
				r.pr3 = (65'(p.ph3) <<< 20) + 65'(p.pl3);
			end
			KRound: begin
				r.tr0 = 41'((p.pr0 + 65'sd4194304) >>> 23);
				r.tr1 = 41'((p.pr1 + 65'sd4194304) >>> 23);
				r.tr2 = 41'((-p.pr2 + 65'sd4194304) >>> 23);
				r.tr3 = 41'((p.pr3 + 65'sd4194304) >>> 23);
			end
			KRad: begin
				r.ax = sat40(42'(gax) + 42'(p.tr0));
				r.ay = sat40(42'(gay) + 42'(p.tr1));
			end
			KTan: begin
				r.ax = sat40(42'(p.ax) + 42'(p.tr2));
				r.ay = sat40(42'(p.ay) + 42'(p.tr3));
			end
			KVel: begin
				r.vx = sat40(42'(p.vx) + 42'(p.ax));
				r.vy = sat40(42'(p.vy) + 42'(p.ay));
			end
			KPos: begin
				r.px = sat40(42'(p.px) + 42'(p.vx));
				r.py = sat40(42'(p.py) + 42'(p.vy));
			end
			default: begin
				if (k >= KRoot0 && k < KDivSet) begin
					i = k - KRoot0;
					bitv = 64'd1 << (62 - 2 * i);
					t64 = p.root + bitv;
					if (p.rem >= t64) begin
						r.rem = p.rem - t64;
						r.root = (p.root >> 1) + bitv;
					end else begin
						r.root = p.root >> 1;
					end
				end else if (k >= KDiv0 && k < KSign) begin
					i = k - KDiv0;
					tx = {p.rqx[31:0], p.dnx[23 - i]};
					ty = {p.rqy[31:0], p.dny[23 - i]};
					if (tx >= {1'b0, p.len}) begin
						r.rqx = tx - {1'b0, p.len};
						r.qx = {p.qx[22:0], 1'b1};
					end else begin
						r.rqx = tx;
						r.qx = {p.qx[22:0], 1'b0};
					end
					if (ty >= {1'b0, p.len}) begin
						r.rqy = ty - {1'b0, p.len};
						r.qy = {p.qy[22:0], 1'b1};
					end else begin
						r.rqy = ty;
						r.qy = {p.qy[22:0], 1'b0};
					end
				end
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/gps_pipe_stage.sv
// one pipeline register stage with valid/ready flow control
`default_nettype none
module gps_pipe_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire gps_pkg::pipe_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output gps_pkg::pipe_t     out_data
);

	logic           valid_q;
	gps_pkg::pipe_t data_q;

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/gravity_particle_step.sv
// top level of the gravity-mode particle step pipeline
// Streams one particle per request in on s_*, one updated particle out on m_*.
// Gravity registers are written via cfg_we/cfg_index/cfg_data; the user writes
// them only while idle (not enforced); scaled gravity updates the next cycle.
// The datapath is a 70-stage register pipeline: normalize, square, a
// 32-stage square root (one result bit per stage), a 24-stage divider
// (one quotient bit per stage, x and y side by side), split multiplies,
// rounding and saturating sums.
// Throughput: one request per cycle, set by the per-stage handshake, while
// m_tready does not stall the last stage.
// Every stage has its own ready, so bubbles close up and s_tready stays high
// while a result waits, until all 70 stages hold data.
// When m_tready is low the last stage holds its result and stalls propagate
// back stage by stage; nothing is lost or repeated.
// Reset clears all stage valid bits and both gravity registers.
`default_nettype none
module gravity_particle_step (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [39:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// position_x, position_y, origin_x, origin_y, vel_x, vel_y,
	// radial_accel, tangent_accel, life_progress, zero pad
	input  wire logic [343:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// new_position_x, new_position_y, new_vel_x, new_vel_y, alive, zero pad
	output logic [167:0]      m_tdata
);

	`include "gravity_particle_step_defines.svh"

	localparam int unsigned Last = gps_pkg::NStages - 1;

	logic signed [39:0] gravity_x_q;
	logic signed [39:0] gravity_y_q;
	logic signed [39:0] gacc_x_q;
	logic signed [39:0] gacc_y_q;
	logic signed [62:0] gprod_x;
	logic signed [62:0] gprod_y;

	gps_pkg::pipe_t in_item;
	gps_pkg::pipe_t stg_d [gps_pkg::NStages];
	gps_pkg::pipe_t stg_q [gps_pkg::NStages];
	logic           vld [gps_pkg::NStages];
	logic           rdy [gps_pkg::NStages];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_x_q <= 40'sd0;
			gravity_y_q <= 40'sd0;
			gacc_x_q <= 40'sd0;
			gacc_y_q <= 40'sd0;
		end else begin
			if (cfg_we && cfg_index == gps_pkg::RegGravityX) gravity_x_q <= cfg_data;
			if (cfg_we && cfg_index == gps_pkg::RegGravityY) gravity_y_q <= cfg_data;
			gacc_x_q <= 40'((gprod_x + 63'sd2147483648) >>> 32);
			gacc_y_q <= 40'((-gprod_y + 63'sd2147483648) >>> 32);
		end
	end

	assign gprod_x = gravity_x_q * gps_pkg::GravScale;
	assign gprod_y = gravity_y_q * gps_pkg::GravScale;

	always_comb begin
		in_item = '0;
		in_item.px = s_tdata[39:0];
		in_item.py = s_tdata[79:40];
		in_item.vx = s_tdata[199:160];
		in_item.vy = s_tdata[239:200];
		in_item.ar = s_tdata[279:240];
		in_item.at = s_tdata[319:280];
		in_item.alive = (s_tdata[336:320] < 17'd65536);
		in_item.rx = $signed({s_tdata[39], s_tdata[39:0]})
			- $signed({s_tdata[119], s_tdata[119:80]});
		in_item.ry = $signed({s_tdata[79], s_tdata[79:40]})
			- $signed({s_tdata[159], s_tdata[159:120]});
	end

	for (genvar k = 0; k < gps_pkg::NStages; k++) begin : g_stage
		logic in_v;
		logic out_r;
		if (k == 0) begin : g_first
			assign stg_d[k] = gps_pkg::stage_op(k, in_item, gacc_x_q, gacc_y_q);
			assign in_v = s_tvalid;
		end else begin : g_mid
			assign stg_d[k] = gps_pkg::stage_op(k, stg_q[k-1], gacc_x_q, gacc_y_q);
			assign in_v = vld[k-1];
		end
		if (k == Last) begin : g_end
			assign out_r = m_tready;
		end else begin : g_link
			assign out_r = rdy[k+1];
		end
		gps_pipe_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (in_v),
			.in_ready  (rdy[k]),
			.in_data   (stg_d[k]),
			.out_valid (vld[k]),
			.out_ready (out_r),
			.out_data  (stg_q[k])
		);
	end

	assign s_tready = rdy[0];
	assign m_tvalid = vld[Last];
	assign m_tdata = {7'd0, stg_q[Last].alive, stg_q[Last].vy, stg_q[Last].vx,
		stg_q[Last].py, stg_q[Last].px};

	`GPS_ASSERT_IMPL(a_front_stall, !s_tready, vld[0], "input stalled with empty first stage")
	`GPS_ASSERT_IMPL(a_len_norm, vld[gps_pkg::KDivSet] && !stg_q[gps_pkg::KDivSet].zero, stg_q[gps_pkg::KDivSet].len[31:30] != 2'b00, "root out of normalized range")
	`GPS_ASSERT_IMPL(a_quot_bound, vld[gps_pkg::KSign - 1] && !stg_q[gps_pkg::KSign - 1].zero, !(stg_q[gps_pkg::KSign - 1].qx[23] && (stg_q[gps_pkg::KSign - 1].qx[22:0] != 23'd0)), "unit quotient above one")

endmodule
`default_nettype wire
